/* rtl/directory_free_block_map_core_macros.svh */
// assertion macros shared by the directory free block map checker
`ifndef DIRECTORY_FREE_BLOCK_MAP_CORE_MACROS_SVH
`define DIRECTORY_FREE_BLOCK_MAP_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define DFBM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define DFBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dfbm_pkg.sv */
// package: types and constants of the directory free block map
`timescale 1ns / 1ps
`default_nettype none

package dfbm_pkg;

   // directory layout
   localparam int EXTENT_BYTES  = 32;
   localparam int OFFSET_W      = 5;
   localparam int POINTER_START = 16;
   localparam logic [7:0] DELETED_MARK = 8'hE5;

   // byte and result widths
   localparam int BYTE_W      = 8;
   localparam int MAX_ROWS    = 16;
   localparam int ROW_BITS    = 16;
   localparam int ROW_INDEX_W = 4;
   localparam int RSP_TDATA_W = 24;

   // controller states
   typedef enum logic {
      ST_PASS,
      ST_EMIT
   } dfbm_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic load_row;
   } dfbm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_byte;
      logic last_row;
      logic out_free;
   } dfbm_status_type;

endpackage

`default_nettype wire

/* rtl/dfbm_ctrl.sv */
// controller: sequences the directory pass and the map read-out
`timescale 1ns / 1ps
`default_nettype none

module dfbm_ctrl
   import dfbm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire dfbm_status_type status,
   output dfbm_cmd_type         cmd
);

   dfbm_state_type state_ff;
   dfbm_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PASS;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_PASS: begin
            if (req_tvalid && status.last_byte) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.last_row) begin
               state_in = ST_PASS;
            end
         end
         default: begin
            state_in = ST_PASS;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = 1'b0;
      cmd.take_byte  = 1'b0;
      cmd.load_row   = 1'b0;
      case (state_ff)
         ST_PASS: begin
            req_tready    = 1'b1;
            cmd.take_byte = req_tvalid;
         end
         ST_EMIT: begin
            cmd.load_row = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/dfbm_datapath.sv */
// datapath: byte position, extent status, used map rows and result register
`timescale 1ns / 1ps
`default_nettype none

module dfbm_datapath
   import dfbm_pkg::*;
#(
   parameter int BLOCK_COUNT          = 256,
   parameter int EXTENTS_IN_DIRECTORY = 32,
   parameter int POINTERS_PER_EXTENT  = 16,
   parameter int MAP_ROW_WIDTH        = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [BYTE_W-1:0]       req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                         rsp_tlast,
   input  wire dfbm_cmd_type            cmd,
   output dfbm_status_type              status
);

   localparam int TOTAL     = EXTENTS_IN_DIRECTORY * EXTENT_BYTES;
   localparam int POS_W     = $clog2(TOTAL);
   localparam int ROWS_ALL  = (BLOCK_COUNT + MAP_ROW_WIDTH - 1) / MAP_ROW_WIDTH;
   localparam int EMIT_ROWS = (ROWS_ALL > MAX_ROWS) ? MAX_ROWS : ROWS_ALL;
   localparam int ROW_W     = (EMIT_ROWS > 1) ? $clog2(EMIT_ROWS) : 1;
   localparam int PTR_END   = POINTER_START + POINTERS_PER_EXTENT;

   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic                              live_ff, live_in;
   logic [EMIT_ROWS-1:0][ROW_BITS-1:0] map_ff, map_in;
   logic [ROW_W-1:0]                  row_ff, row_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]            rsp_data_ff, rsp_data_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [OFFSET_W-1:0] offset;
   logic                at_status;
   logic                in_ptr_field;
   logic                clear_map;
   logic                mark;
   logic [ROW_BITS-1:0] row_used;

   // where the current byte sits in its extent
   assign offset       = pos_ff[OFFSET_W-1:0];
   assign at_status    = (offset == '0);
   assign in_ptr_field = ({1'b0, offset} >= (OFFSET_W+1)'(POINTER_START)) &&
                         ({1'b0, offset} <  (OFFSET_W+1)'(PTR_END));
   assign clear_map    = cmd.take_byte && (pos_ff == '0);
   assign mark         = cmd.take_byte && in_ptr_field && live_ff &&
                         (req_tdata != '0) &&
                         ({1'b0, req_tdata} < (BYTE_W+1)'(BLOCK_COUNT));

   // status back to the controller
   assign status.last_byte = (pos_ff == POS_W'(TOTAL - 1));
   assign status.last_row  = (row_ff == ROW_W'(EMIT_ROWS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // byte position and extent status
   always_comb begin
      pos_in  = pos_ff;
      live_in = live_ff;
      if (cmd.take_byte) begin
         pos_in = status.last_byte ? '0 : pos_ff + POS_W'(1);
         if (at_status) begin
            live_in = (req_tdata != DELETED_MARK);
         end
      end
   end

   // map update: cleared at pass start but for block 0, one bit set per nonzero in-range pointer byte of a live extent
   always_comb begin
      int blk;
      blk = 0;
      for (int r = 0; r < EMIT_ROWS; r++) begin
         for (int c = 0; c < ROW_BITS; c++) begin
            blk = r * MAP_ROW_WIDTH + c;
            if ((c < MAP_ROW_WIDTH) && (blk < BLOCK_COUNT)) begin
               if (clear_map) begin
                  map_in[r][c] = (blk == 0);
               end else begin
                  map_in[r][c] = map_ff[r][c] |
                                 (mark && (req_tdata == blk[BYTE_W-1:0]));
               end
            end else begin
               map_in[r][c] = 1'b0;
            end
         end
      end
   end

   // read-out row counter and result register
   assign row_used = map_ff[row_ff];

   always_comb begin
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_row) begin
         row_in       = status.last_row ? '0 : row_ff + ROW_W'(1);
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(RSP_TDATA_W - ROW_BITS - ROW_INDEX_W)'(0), row_used,
                         ROW_INDEX_W'(row_ff)};
         rsp_last_in  = status.last_row;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         live_ff      <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         map_ff       <= (EMIT_ROWS * ROW_BITS)'(1);
      end else begin
         pos_ff       <= pos_in;
         live_ff      <= live_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/directory_free_block_map_core.sv */
// Directory free block map: one directory byte accepted per cycle during a pass.
// A pass is EXTENTS_IN_DIRECTORY*32 bytes; after the last byte the state register moves to
// read-out, and the rows go out through the result register, one row per cycle while the
// result side accepts, min(ceil(BLOCK_COUNT/MAP_ROW_WIDTH),16) rows, with input held off
// during the read-out. Back-pressure on the result side stretches the read-out.
// Synchronous active-high reset: position zero, block 0 used, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module directory_free_block_map_core
   import dfbm_pkg::*;
#(
   parameter int BLOCK_COUNT          = 256,
   parameter int EXTENTS_IN_DIRECTORY = 32,
   parameter int POINTERS_PER_EXTENT  = 16,
   parameter int MAP_ROW_WIDTH        = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [BYTE_W-1:0]       req_tdata,   // [7:0] dir_byte
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,   // [3:0] row_index, [19:4] row_used
   output logic                         rsp_tlast    // last_row
);

   dfbm_cmd_type    cmd;
   dfbm_status_type status;

   // pass and read-out sequencing
   dfbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // map storage and result register
   dfbm_datapath #(
      .BLOCK_COUNT          (BLOCK_COUNT),
      .EXTENTS_IN_DIRECTORY (EXTENTS_IN_DIRECTORY),
      .POINTERS_PER_EXTENT  (POINTERS_PER_EXTENT),
      .MAP_ROW_WIDTH        (MAP_ROW_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

/* rtl/dfbm_checker.sv */
// checker on the ports of the directory free block map, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "directory_free_block_map_core_macros.svh"

module dfbm_checker
   import dfbm_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_tready,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                    rsp_tlast
);

   // a stalled result stays offered
   `DFBM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

   // a stalled result keeps its payload
   `DFBM_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // no directory byte taken while rows of the map are still to come
   `DFBM_ASSERT_NOW(a_no_take_midmap, rsp_tvalid && !rsp_tlast, !req_tready, "input open during map read-out")

   // block zero always reads as used
   `DFBM_ASSERT_NOW(a_block_zero, rsp_tvalid && (rsp_tdata[3:0] == 4'd0), rsp_tdata[4], "block zero reported free")

endmodule

bind directory_free_block_map_core dfbm_checker u_dfbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
